[rtl/ght_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ght_pkg
// Shared types and codes of the generational handle table: operation kinds,
// result status codes and the result word passed to the output register.
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_CHECK   = 2'd2,
    KIND_READ    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_STALE  = 2'd2,
    STAT_BEYOND = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  slot;
    logic [15:0] gen;
    logic [8:0]  count;
  } result_t;

endpackage
`default_nettype wire

[rtl/ght_out_reg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ght_out_reg
// Output register of the handle table: holds one finished result word on the
// master stream until it is taken.
// ----------------------------------------------------------------------------
module ght_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire ght_pkg::result_t     res,
  output logic                      free,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // tdata: out_slot[7:0], out_generation[23:8], active_count_out[32:24], zero
  output logic [ght_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]                m_axis_tuser
);
  import ght_pkg::*;

  result_t held;

  assign free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (load) begin
      held <= res;
    end
  end

  assign m_axis_tdata = {7'd0, held.count, held.gen, held.slot};
  assign m_axis_tuser = held.status;

endmodule
`default_nettype wire

[rtl/generational_handle_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// generational_handle_table
// Slot map handing out (slot, generation) handles: free-slot stack, dense
// active list with swap-on-remove, per-slot back pointer, live bit and a
// 16-bit generation that skips zero on wrap.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata: slot, generation, position
//                                           tuser: kind
//  m_axis    out  m_axis_tvalid/tready      tdata: slot, generation, count
//                                           tuser: status
//  cfg       in   cfg_valid/cfg_ready       cfg_data: max_active
//
// One operation at a time. Check and rejected operations finish in ST_ONE,
// insert and read in ST_TWO, release in ST_THREE; the chain of dependent reads
// through the one read port of each memory sets these steps.
// Reset clears the state and the counters and sets max_active to 256 only; a
// high-water mark of used slots stands in for the initial memory contents, so there is no clearing pass.
// The next word is accepted while a result waits; the last step holds until
// the output register is free.
// ----------------------------------------------------------------------------
module generational_handle_table #(
  parameter int SLOTS = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: handle_slot[7:0], handle_generation[23:8], list_position[31:24]
  input  wire logic [ght_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // tuser: kind[1:0]
  input  wire logic [1:0]                  s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // tdata: out_slot[7:0], out_generation[23:8], active_count_out[32:24], zero
  output logic [ght_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]                       m_axis_tuser,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [8:0]                  cfg_data
);
  import ght_pkg::*;

  localparam int SW     = $clog2(SLOTS);
  localparam int PDEPTH = (SLOTS < 512) ? SLOTS : 512;
  localparam int PW     = $clog2(PDEPTH);
  localparam int PWW    = 2 * SW;
  localparam int SWW    = 17 + PW;

  typedef enum logic [1:0] {ST_IDLE, ST_ONE, ST_TWO, ST_THREE} state_t;

  state_t      state;
  kind_t       op_kind;
  logic [7:0]  h_slot;
  logic [15:0] h_gen;
  logic [7:0]  h_pos;
  logic [8:0]  count;
  logic [8:0]  hwm;
  logic [8:0]  max_active;
  logic [SW-1:0] cur_slot;
  logic [SW-1:0] mover;
  logic [PW-1:0] gap;
  logic [15:0] ng;

  // position memory: {free stack entry, active list entry}
  logic [PWW-1:0] p_mem [PDEPTH];
  logic [PWW-1:0] p_rd;
  logic           p_re, p_we;
  logic [PW-1:0]  p_ra, p_wa;
  logic [PWW-1:0] p_wd;

  // slot memory: {generation, live, position in active list}
  logic [SWW-1:0] s_mem [SLOTS];
  logic [SWW-1:0] s_rd;
  logic           s_re, s_we;
  logic [SW-1:0]  s_ra, s_wa;
  logic [SWW-1:0] s_wd;

  always_ff @(posedge clk) begin
    if (p_we) begin
      p_mem[p_wa] <= p_wd;
    end
    if (p_re) begin
      p_rd <= p_mem[p_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      s_mem[s_wa] <= s_wd;
    end
    if (s_re) begin
      s_rd <= s_mem[s_ra];
    end
  end

  logic        in_acc;
  logic        ofree;
  logic        finish;
  logic        done;
  result_t     res;
  logic [8:0]  lim;
  logic [8:0]  count_m1;
  logic [8:0]  count_p1;
  logic [SW-1:0] in_slot_idx;
  logic [SW-1:0] h_slot_idx;
  logic [PW-1:0] in_pos_idx;
  logic [15:0] rd_gen;
  logic        rd_live;
  logic [PW-1:0] rd_pos;
  logic [SW-1:0] p_al;
  logic [SW-1:0] p_fs;
  logic [SW-1:0] s_new;
  logic        h_valid;
  logic        fresh;
  logic [15:0] g_ins;
  logic [15:0] g_bump;
  state_t      state_next;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  assign lim      = (32'(max_active) < PDEPTH) ? max_active : 9'(PDEPTH);
  assign count_m1 = count - 9'd1;
  assign count_p1 = count + 9'd1;

  assign in_slot_idx = SW'(32'(s_axis_tdata[7:0]));
  assign in_pos_idx  = PW'(32'(s_axis_tdata[31:24]));
  assign h_slot_idx  = SW'(32'(h_slot));

  assign rd_gen  = s_rd[SWW-1 -: 16];
  assign rd_live = s_rd[PW];
  assign rd_pos  = s_rd[PW-1:0];
  assign p_fs    = p_rd[PWW-1 -: SW];
  assign p_al    = p_rd[SW-1:0];

  // slots at or above the high-water mark were never handed out
  assign h_valid = (32'(h_slot) < SLOTS) && (h_gen != 16'd0)
                   && (32'(h_slot) < 32'(hwm)) && rd_live && (rd_gen == h_gen);
  assign g_bump  = (rd_gen == 16'hFFFF) ? 16'd1 : rd_gen + 16'd1;
  assign fresh   = 32'(cur_slot) >= 32'(hwm);
  assign g_ins   = (fresh || rd_gen == 16'd0) ? 16'd1 : rd_gen;
  // a free-stack entry at or above the mark was never written; the count is its slot
  assign s_new   = (count >= hwm) ? SW'(32'(count)) : p_fs;

  always_comb begin
    p_re = 1'b0;
    p_ra = '0;
    p_we = 1'b0;
    p_wa = '0;
    p_wd = '0;
    s_re = 1'b0;
    s_ra = '0;
    s_we = 1'b0;
    s_wa = '0;
    s_wd = '0;
    finish = 1'b0;
    res = '{status: STAT_OK, slot: 8'd0, gen: 16'd0, count: count};
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          p_re = 1'b1;
          p_ra = (kind_t'(s_axis_tuser) == KIND_READ) ? in_pos_idx : count[PW-1:0];
          s_re = 1'b1;
          s_ra = in_slot_idx;
          state_next = ST_ONE;
        end
      end
      ST_ONE: begin
        unique case (op_kind)
          KIND_INSERT: begin
            if (count >= lim) begin
              finish = 1'b1;
              res.status = STAT_FULL;
            end else begin
              p_we = 1'b1;
              p_wa = count[PW-1:0];
              p_wd = {p_fs, s_new};
              s_re = 1'b1;
              s_ra = s_new;
              state_next = ST_TWO;
            end
          end
          KIND_RELEASE: begin
            if (!h_valid || count == 9'd0) begin
              finish = 1'b1;
              res.status = STAT_STALE;
            end else begin
              s_we = 1'b1;
              s_wa = h_slot_idx;
              s_wd = {g_bump, 1'b0, rd_pos};
              // read the last list entry and push the slot there at once
              p_re = 1'b1;
              p_ra = count_m1[PW-1:0];
              p_we = 1'b1;
              p_wa = count_m1[PW-1:0];
              p_wd = {h_slot_idx, {SW{1'b0}}};
              state_next = ST_TWO;
            end
          end
          KIND_CHECK: begin
            finish = 1'b1;
            if (h_valid) begin
              res.slot = h_slot;
              res.gen  = rd_gen;
            end else begin
              res.status = STAT_STALE;
            end
          end
          KIND_READ: begin
            if (32'(h_pos) >= 32'(count)) begin
              finish = 1'b1;
              res.status = STAT_BEYOND;
            end else begin
              s_re = 1'b1;
              s_ra = p_al;
              state_next = ST_TWO;
            end
          end
          default: ;
        endcase
      end
      ST_TWO: begin
        unique case (op_kind)
          KIND_INSERT: begin
            finish = 1'b1;
            res.slot  = 8'(cur_slot);
            res.gen   = g_ins;
            res.count = count_p1;
            s_we = ofree;
            s_wa = cur_slot;
            s_wd = {g_ins, 1'b1, count[PW-1:0]};
          end
          KIND_RELEASE: begin
            // move the last entry into the gap
            p_we = 1'b1;
            p_wa = gap;
            p_wd = {cur_slot, p_al};
            s_re = 1'b1;
            s_ra = p_al;
            state_next = ST_THREE;
          end
          default: begin
            finish = 1'b1;
            res.slot = 8'(cur_slot);
            res.gen  = rd_gen;
          end
        endcase
      end
      ST_THREE: begin
        finish = 1'b1;
        res.slot  = 8'(cur_slot);
        res.gen   = ng;
        res.count = count_m1;
        s_we = ofree;
        s_wa = mover;
        s_wd = {rd_gen, rd_live, gap};
      end
      default: ;
    endcase
    if (finish) begin
      state_next = ofree ? ST_IDLE : state;
    end
    if (res.status != STAT_OK) begin
      res.count = count;
    end
  end

  assign done = finish && ofree;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= 9'd0;
      hwm        <= 9'd0;
      max_active <= 9'd256;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        max_active <= cfg_data;
      end
      if (done && res.status == STAT_OK) begin
        if (op_kind == KIND_INSERT) begin
          count <= count_p1;
          if (count_p1 > hwm) begin
            hwm <= count_p1;
          end
        end else if (op_kind == KIND_RELEASE) begin
          count <= count_m1;
        end
      end
    end
    if (in_acc) begin
      op_kind <= kind_t'(s_axis_tuser);
      h_slot  <= s_axis_tdata[7:0];
      h_gen   <= s_axis_tdata[23:8];
      h_pos   <= s_axis_tdata[31:24];
    end
    if (state == ST_ONE) begin
      if (op_kind == KIND_INSERT) begin
        cur_slot <= s_new;
      end else if (op_kind == KIND_READ) begin
        cur_slot <= p_al;
      end else begin
        cur_slot <= h_slot_idx;
      end
      gap <= rd_pos;
      ng  <= g_bump;
    end
    if (state == ST_TWO) begin
      mover <= p_al;
    end
  end

  ght_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (done),
    .res           (res),
    .free          (ofree),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
`default_nettype wire
